// ===== hdl/blre_pkg.sv =====
`default_nettype none

package blre_pkg;

   // Datapath widths.
   localparam int MV_W       = 12;
   localparam int DISP_W     = 15;
   localparam int VOLT_W     = 16;
   localparam int GAIN_W     = 16;
   localparam int OFFS_W     = 14;
   localparam int LEVEL_W    = 15;
   localparam int PCT_W      = 7;
   localparam int TICK_W     = 10;
   localparam int HALF_W     = 14;
   localparam int ELAPSED_W  = 16;
   localparam int BYTE_W     = 8;
   localparam int FRAME_BITS = 24;
   localparam int BITCNT_W   = 5;
   localparam int PROD_W     = 32;
   localparam int REM_W      = 15;
   localparam int NUM_W      = 26;
   localparam int DIVCNT_W   = 4;
   localparam int TICKS_W    = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PC_W       = 5;

   // Register reset values.
   localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd17005;
   localparam logic [OFFS_W-1:0]  OFFSET_RESET = 14'd466;
   localparam logic [LEVEL_W-1:0] FULL_RESET   = 15'd7400;
   localparam logic [LEVEL_W-1:0] LOW_RESET    = 15'd6600;
   localparam logic [LEVEL_W-1:0] ALARM_RESET  = 15'd6400;
   localparam logic [PCT_W-1:0]   PCT_RESET    = 7'd10;
   localparam logic [TICK_W-1:0]  TICK_RESET   = 10'd100;
   localparam logic [HALF_W-1:0]  HALF_RESET   = 14'd250;

   // floor(x/10) equals (x*6554)>>16 for every x below 16384.
   localparam logic [15:0] TENTH_RECIP = 16'd6554;

   localparam logic [VOLT_W-1:0]  VOLT_POS_SAT  = 16'h7FFF;
   localparam logic [VOLT_W-1:0]  VOLT_NEG_SAT  = 16'h8000;
   localparam logic [BYTE_W-1:0]  BYTE_MAX      = 8'd255;
   localparam logic [LEVEL_W-1:0] PERCENT_DIV   = 15'd100;
   localparam logic [PCT_W-1:0]   ROUND_BIAS    = 7'd50;
   localparam logic [DIVCNT_W-1:0] DIV_STEPS    = 4'd8;
   localparam logic [DIVCNT_W-1:0] DIV_LAST_STEP = 4'd1;
   localparam logic [BITCNT_W-1:0] LAST_BIT     = 5'd23;

   // WS2812 pulse widths in 25 ns ticks.
   localparam logic [TICKS_W-1:0] ONE_HIGH  = 6'd32;
   localparam logic [TICKS_W-1:0] ONE_LOW   = 6'd18;
   localparam logic [TICKS_W-1:0] ZERO_HIGH = 6'd14;
   localparam logic [TICKS_W-1:0] ZERO_LOW  = 6'd32;

   // Microprogram addresses.
   localparam logic [PC_W-1:0] PC_IDLE       = 5'd0;
   localparam logic [PC_W-1:0] PC_MUL_TENTH  = 5'd1;
   localparam logic [PC_W-1:0] PC_DISP       = 5'd2;
   localparam logic [PC_W-1:0] PC_MUL_GAIN   = 5'd3;
   localparam logic [PC_W-1:0] PC_VOLT       = 5'd4;
   localparam logic [PC_W-1:0] PC_CLASSIFY   = 5'd5;
   localparam logic [PC_W-1:0] PC_RRAT_START = 5'd6;
   localparam logic [PC_W-1:0] PC_RRAT_STEP  = 5'd7;
   localparam logic [PC_W-1:0] PC_RRAT_STORE = 5'd8;
   localparam logic [PC_W-1:0] PC_BRAT_START = 5'd9;
   localparam logic [PC_W-1:0] PC_BRAT_STEP  = 5'd10;
   localparam logic [PC_W-1:0] PC_BRAT_STORE = 5'd11;
   localparam logic [PC_W-1:0] PC_RSCL_START = 5'd12;
   localparam logic [PC_W-1:0] PC_RSCL_STEP  = 5'd13;
   localparam logic [PC_W-1:0] PC_RSCL_STORE = 5'd14;
   localparam logic [PC_W-1:0] PC_BSCL_START = 5'd15;
   localparam logic [PC_W-1:0] PC_BSCL_STEP  = 5'd16;
   localparam logic [PC_W-1:0] PC_BSCL_STORE = 5'd17;
   localparam logic [PC_W-1:0] PC_FRAME      = 5'd18;
   localparam logic [PC_W-1:0] PC_EMIT       = 5'd19;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_GAIN   = 3'd0,
      CSR_CAL_OFFSET = 3'd1,
      CSR_FULL_LEVEL = 3'd2,
      CSR_LOW_LEVEL  = 3'd3,
      CSR_ALARM      = 3'd4,
      CSR_BRIGHTNESS = 3'd5,
      CSR_TICK       = 3'd6,
      CSR_BLINK_HALF = 3'd7
   } csr_reg_type;

   typedef enum logic [3:0] {
      OP_NONE      = 4'd0,
      OP_TAKE      = 4'd1,
      OP_MUL_TENTH = 4'd2,
      OP_DISP      = 4'd3,
      OP_MUL_GAIN  = 4'd4,
      OP_VOLT      = 4'd5,
      OP_CLASSIFY  = 4'd6,
      OP_DIV_START = 4'd7,
      OP_DIV_STEP  = 4'd8,
      OP_DIV_STORE = 4'd9,
      OP_FRAME     = 4'd10,
      OP_EMIT      = 4'd11
   } op_type;

   typedef enum logic [2:0] {
      SEQ_NEXT      = 3'd0,
      SEQ_JUMP      = 3'd1,
      SEQ_WAIT_REQ  = 3'd2,
      SEQ_DIV_LOOP  = 3'd3,
      SEQ_SKIP_GRAD = 3'd4,
      SEQ_EMIT      = 3'd5
   } seq_type;

   typedef enum logic [1:0] {
      SRC_RED_RATIO  = 2'd0,
      SRC_BLUE_RATIO = 2'd1,
      SRC_SCALE_RED  = 2'd2,
      SRC_SCALE_BLUE = 2'd3
   } div_src_type;

   typedef enum logic {
      DST_RED  = 1'b0,
      DST_BLUE = 1'b1
   } div_dst_type;

   typedef struct packed {
      op_type           op;
      seq_type          seq;
      div_src_type      src;
      div_dst_type      dst;
      logic [PC_W-1:0]  target;
   } ctrl_word_type;

   // Control store of the sequencer.
   function automatic ctrl_word_type ucode(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w.op     = OP_NONE;
      w.seq    = SEQ_NEXT;
      w.src    = SRC_RED_RATIO;
      w.dst    = DST_RED;
      w.target = PC_IDLE;
      case (pc)
         PC_IDLE: begin
            w.op  = OP_TAKE;
            w.seq = SEQ_WAIT_REQ;
         end
         PC_MUL_TENTH: w.op = OP_MUL_TENTH;
         PC_DISP:      w.op = OP_DISP;
         PC_MUL_GAIN:  w.op = OP_MUL_GAIN;
         PC_VOLT:      w.op = OP_VOLT;
         PC_CLASSIFY: begin
            w.op     = OP_CLASSIFY;
            w.seq    = SEQ_SKIP_GRAD;
            w.target = PC_RSCL_START;
         end
         PC_RRAT_START: begin
            w.op  = OP_DIV_START;
            w.src = SRC_RED_RATIO;
         end
         PC_RRAT_STEP: begin
            w.op  = OP_DIV_STEP;
            w.seq = SEQ_DIV_LOOP;
         end
         PC_RRAT_STORE: begin
            w.op  = OP_DIV_STORE;
            w.dst = DST_RED;
         end
         PC_BRAT_START: begin
            w.op  = OP_DIV_START;
            w.src = SRC_BLUE_RATIO;
         end
         PC_BRAT_STEP: begin
            w.op  = OP_DIV_STEP;
            w.seq = SEQ_DIV_LOOP;
         end
         PC_BRAT_STORE: begin
            w.op  = OP_DIV_STORE;
            w.dst = DST_BLUE;
         end
         PC_RSCL_START: begin
            w.op  = OP_DIV_START;
            w.src = SRC_SCALE_RED;
         end
         PC_RSCL_STEP: begin
            w.op  = OP_DIV_STEP;
            w.seq = SEQ_DIV_LOOP;
         end
         PC_RSCL_STORE: begin
            w.op  = OP_DIV_STORE;
            w.dst = DST_RED;
         end
         PC_BSCL_START: begin
            w.op  = OP_DIV_START;
            w.src = SRC_SCALE_BLUE;
         end
         PC_BSCL_STEP: begin
            w.op  = OP_DIV_STEP;
            w.seq = SEQ_DIV_LOOP;
         end
         PC_BSCL_STORE: begin
            w.op  = OP_DIV_STORE;
            w.dst = DST_BLUE;
         end
         PC_FRAME: w.op = OP_FRAME;
         PC_EMIT: begin
            w.op     = OP_EMIT;
            w.seq    = SEQ_EMIT;
            w.target = PC_IDLE;
         end
         default: begin
            w.seq    = SEQ_JUMP;
            w.target = PC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/battery_level_rgb_led_encoder_top.sv =====
`default_nettype none

// Channel  Direction  Handshake              Content
// req      in         req_tvalid/req_tready  one monitor tick: ADC reading and its valid flag
// rsp      out        rsp_tvalid/rsp_tready  one WS2812 pulse word, 24 per tick, GRB MSB first
// csr      in         csr_we                 register write, no wait state, no read-back
//
// Each tick runs from the accepting edge back to idle through the microprogram: five
// arithmetic steps, a shared 8-step restoring divider used twice for the gradient ratios
// (skipped when blue, blinking red, fixed red or dark is shown) and twice for brightness
// scaling, and the serial emission of the frame, which holds while rsp stalls. A new
// tick is taken only in idle.
// Reset is synchronous and active high; it loads the register defaults, clears the
// blink counter, lights the blink phase and returns the sequencer to idle.

module battery_level_rgb_led_encoder_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,   // [11:0] pin_millivolts
   input  logic                                req_tuser,   // [0] reading_ok
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] bit_value, [6:1] high_ticks, [12:7] low_ticks, [28:13] battery_mv
   output logic [31:0]                         rsp_tdata,
   output logic                                rsp_tlast,   // frame_end
   output logic                                rsp_tuser,   // [0] voltage_valid
   input  logic                                csr_we,
   input  logic [blre_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [blre_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import blre_pkg::*;

   // Sequencer.
   logic [PC_W-1:0]       pc_ff, pc_in;
   ctrl_word_type         ctrl;

   // Configuration registers.
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic [OFFS_W-1:0]     offset_ff, offset_in;
   logic [LEVEL_W-1:0]    full_ff, full_in;
   logic [LEVEL_W-1:0]    low_ff, low_in;
   logic [LEVEL_W-1:0]    alarm_ff, alarm_in;
   logic [PCT_W-1:0]      pct_ff, pct_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [HALF_W-1:0]     half_ff, half_in;

   // Blink state.
   logic [ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic                  phase_ff, phase_in;

   // Datapath registers.
   logic                  ok_ff, ok_in;
   logic [MV_W-1:0]       mv_ff, mv_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [DISP_W-1:0]     disp_ff, disp_in;
   logic [VOLT_W-1:0]     volt_ff, volt_in;
   logic [BYTE_W-1:0]     red_ff, red_in;
   logic [BYTE_W-1:0]     blue_ff, blue_in;

   // Divider registers.
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [BYTE_W-1:0]     quo_ff, quo_in;
   logic [LEVEL_W-1:0]    den_ff, den_in;
   logic [DIVCNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                  div_zero_ff, div_zero_in;
   logic                  div_sat_ff, div_sat_in;

   // Output frame.
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [BITCNT_W-1:0]   bit_cnt_ff, bit_cnt_in;

   // Combinational helpers.
   logic                  take, give, last_bit, grad_go;
   logic [15:0]           mul_a, mul_b;
   logic [PROD_W-1:0]     mul_p;
   logic signed [18:0]    cal_sum;
   logic [VOLT_W-1:0]     volt_sat;
   logic                  ge_full, lt_alarm, span_pos, toggle;
   logic [ELAPSED_W-1:0]  elapsed_sum;
   logic [16:0]           diff_red, diff_blue, diff_sel;
   logic [NUM_W-1:0]      diff_ext, ratio_num, scale_num, num_sel;
   logic [BYTE_W-1:0]     scale_x;
   logic [14:0]           scale_prod;
   logic [LEVEL_W-1:0]    den_sel;
   logic [16:0]           trial;
   logic                  qbit;
   logic [BYTE_W-1:0]     div_result;
   logic                  out_bit;

   assign ctrl       = ucode(pc_ff);
   assign req_tready = (ctrl.op == OP_TAKE);
   assign rsp_tvalid = (ctrl.op == OP_EMIT);
   assign take       = req_tvalid && req_tready;
   assign give       = rsp_tvalid && rsp_tready;
   assign last_bit   = (bit_cnt_ff == LAST_BIT);

   // The word on rsp comes straight from the frame shifter and the held voltage.
   assign out_bit   = frame_ff[FRAME_BITS-1];
   assign rsp_tdata = {3'b000, volt_ff,
                       (out_bit ? ONE_LOW : ZERO_LOW),
                       (out_bit ? ONE_HIGH : ZERO_HIGH),
                       out_bit};
   assign rsp_tlast = last_bit;
   assign rsp_tuser = ok_ff;

   // The multiplier shared by both products: first the reciprocal of ten, then the gain.
   always_comb begin
      if (ctrl.op == OP_MUL_TENTH) begin
         mul_a = {4'b0000, mv_ff};
         mul_b = TENTH_RECIP;
      end else begin
         mul_a = gain_ff;
         mul_b = {1'b0, disp_ff};
      end
      mul_p = mul_a * mul_b;
   end

   // Gain result in Q2.14 dropped to whole millivolts, plus the offset, then
   // saturated to the signed 16-bit range.
   always_comb begin
      cal_sum = $signed({2'b00, prod_ff[30:14]})
              + $signed({{5{offset_ff[OFFS_W-1]}}, offset_ff});
      if (!cal_sum[18] && (cal_sum[17:15] != 3'b000)) begin
         volt_sat = VOLT_POS_SAT;
      end else if (cal_sum[18] && (cal_sum[17:15] != 3'b111)) begin
         volt_sat = VOLT_NEG_SAT;
      end else begin
         volt_sat = cal_sum[15:0];
      end
   end

   // Color decision terms.
   assign ge_full     = $signed(volt_ff) >= $signed({1'b0, full_ff});
   assign lt_alarm    = $signed(volt_ff) < $signed({1'b0, alarm_ff});
   assign span_pos    = full_ff > low_ff;
   assign elapsed_sum = elapsed_ff + {6'b000000, tick_ff};
   assign toggle      = elapsed_sum >= {2'b00, half_ff};
   assign grad_go     = ok_ff && !ge_full && !lt_alarm && span_pos;

   // Divider operand selection.
   always_comb begin
      diff_red  = {2'b00, full_ff} - {volt_ff[VOLT_W-1], volt_ff};
      diff_blue = {volt_ff[VOLT_W-1], volt_ff} - {2'b00, low_ff};
      diff_sel  = (ctrl.src == SRC_BLUE_RATIO) ? diff_blue : diff_red;
      diff_ext  = {{9{diff_sel[16]}}, diff_sel};
      // Times 255 as times 256 minus one.
      ratio_num = {diff_ext[17:0], 8'h00} - diff_ext;
      scale_x   = (ctrl.src == SRC_SCALE_BLUE) ? blue_ff : red_ff;
      scale_prod = scale_x * pct_ff;
      scale_num = {11'b0, scale_prod} + {19'b0, ROUND_BIAS};
      case (ctrl.src)
         SRC_RED_RATIO, SRC_BLUE_RATIO: begin
            num_sel = ratio_num;
            den_sel = full_ff - low_ff;
         end
         SRC_SCALE_RED, SRC_SCALE_BLUE: begin
            num_sel = scale_num;
            den_sel = PERCENT_DIV;
         end
         default: begin
            num_sel = scale_num;
            den_sel = PERCENT_DIV;
         end
      endcase
   end

   // One restoring step: shift in the next dividend bit and subtract if it fits.
   assign trial = {1'b0, rem_ff, quo_ff[BYTE_W-1]} - {2'b00, den_ff};
   assign qbit  = !trial[16];

   // A negative numerator gives zero; a quotient that would reach 256 gives 255.
   always_comb begin
      if (div_zero_ff) begin
         div_result = '0;
      end else if (div_sat_ff) begin
         div_result = BYTE_MAX;
      end else begin
         div_result = quo_ff;
      end
   end

   // Datapath and register next values.
   always_comb begin
      gain_in     = gain_ff;
      offset_in   = offset_ff;
      full_in     = full_ff;
      low_in      = low_ff;
      alarm_in    = alarm_ff;
      pct_in      = pct_ff;
      tick_in     = tick_ff;
      half_in     = half_ff;
      elapsed_in  = elapsed_ff;
      phase_in    = phase_ff;
      ok_in       = ok_ff;
      mv_in       = mv_ff;
      prod_in     = prod_ff;
      disp_in     = disp_ff;
      volt_in     = volt_ff;
      red_in      = red_ff;
      blue_in     = blue_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      den_in      = den_ff;
      div_cnt_in  = div_cnt_ff;
      div_zero_in = div_zero_ff;
      div_sat_in  = div_sat_ff;
      frame_in    = frame_ff;
      bit_cnt_in  = bit_cnt_ff;

      if (csr_we) begin
         case (csr_reg_type'(csr_index))
            CSR_CAL_GAIN:   gain_in   = csr_wdata[GAIN_W-1:0];
            CSR_CAL_OFFSET: offset_in = csr_wdata[OFFS_W-1:0];
            CSR_FULL_LEVEL: full_in   = csr_wdata[LEVEL_W-1:0];
            CSR_LOW_LEVEL:  low_in    = csr_wdata[LEVEL_W-1:0];
            CSR_ALARM:      alarm_in  = csr_wdata[LEVEL_W-1:0];
            CSR_BRIGHTNESS: pct_in    = csr_wdata[PCT_W-1:0];
            CSR_TICK:       tick_in   = csr_wdata[TICK_W-1:0];
            CSR_BLINK_HALF: half_in   = csr_wdata[HALF_W-1:0];
            default: ;
         endcase
      end

      case (ctrl.op)
         OP_TAKE: begin
            if (take) begin
               ok_in = req_tuser;
               mv_in = req_tdata[MV_W-1:0];
            end
         end
         OP_MUL_TENTH, OP_MUL_GAIN: prod_in = mul_p;
         OP_DISP: begin
            // mv*61/10 is 6*mv plus floor(mv/10).
            disp_in = {1'b0, mv_ff, 2'b00} + {2'b00, mv_ff, 1'b0}
                    + {6'b000000, prod_ff[24:16]};
         end
         OP_VOLT: volt_in = ok_ff ? volt_sat : '0;
         OP_CLASSIFY: begin
            red_in  = '0;
            blue_in = '0;
            if (!ok_ff) begin
               red_in = '0;
            end else if (ge_full) begin
               blue_in = BYTE_MAX;
            end else if (lt_alarm) begin
               elapsed_in = toggle ? '0 : elapsed_sum;
               phase_in   = phase_ff ^ toggle;
               red_in     = (phase_ff ^ toggle) ? BYTE_MAX : '0;
            end else if (!span_pos) begin
               red_in = BYTE_MAX;
            end
         end
         OP_DIV_START: begin
            den_in      = den_sel;
            div_zero_in = num_sel[NUM_W-1];
            div_sat_in  = !num_sel[NUM_W-1]
                        && (num_sel[24:0] >= {2'b00, den_sel, 8'h00});
            rem_in      = num_sel[22:8];
            quo_in      = num_sel[7:0];
            div_cnt_in  = DIV_STEPS;
         end
         OP_DIV_STEP: begin
            rem_in     = qbit ? trial[REM_W-1:0] : {rem_ff[REM_W-2:0], quo_ff[BYTE_W-1]};
            quo_in     = {quo_ff[BYTE_W-2:0], qbit};
            div_cnt_in = div_cnt_ff - DIV_LAST_STEP;
         end
         OP_DIV_STORE: begin
            if (ctrl.dst == DST_BLUE) begin
               blue_in = div_result;
            end else begin
               red_in = div_result;
            end
         end
         OP_FRAME: begin
            // Green is never lit.
            frame_in   = {8'h00, red_ff, blue_ff};
            bit_cnt_in = '0;
         end
         OP_EMIT: begin
            if (give) begin
               frame_in   = {frame_ff[FRAME_BITS-2:0], 1'b0};
               bit_cnt_in = bit_cnt_ff + {{(BITCNT_W-1){1'b0}}, 1'b1};
            end
         end
         default: ;
      endcase
   end

   // Step counter with conditional jumps.
   always_comb begin
      case (ctrl.seq)
         SEQ_NEXT:      pc_in = pc_ff + {{(PC_W-1){1'b0}}, 1'b1};
         SEQ_JUMP:      pc_in = ctrl.target;
         SEQ_WAIT_REQ:  pc_in = take ? pc_ff + {{(PC_W-1){1'b0}}, 1'b1} : pc_ff;
         SEQ_DIV_LOOP:  pc_in = (div_cnt_ff != DIV_LAST_STEP) ? pc_ff
                              : pc_ff + {{(PC_W-1){1'b0}}, 1'b1};
         SEQ_SKIP_GRAD: pc_in = grad_go ? pc_ff + {{(PC_W-1){1'b0}}, 1'b1} : ctrl.target;
         SEQ_EMIT:      pc_in = (give && last_bit) ? ctrl.target : pc_ff;
         default:       pc_in = PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= PC_IDLE;
         gain_ff    <= GAIN_RESET;
         offset_ff  <= OFFSET_RESET;
         full_ff    <= FULL_RESET;
         low_ff     <= LOW_RESET;
         alarm_ff   <= ALARM_RESET;
         pct_ff     <= PCT_RESET;
         tick_ff    <= TICK_RESET;
         half_ff    <= HALF_RESET;
         elapsed_ff <= '0;
         phase_ff   <= 1'b1;
         div_cnt_ff <= '0;
         bit_cnt_ff <= '0;
      end else begin
         pc_ff      <= pc_in;
         gain_ff    <= gain_in;
         offset_ff  <= offset_in;
         full_ff    <= full_in;
         low_ff     <= low_in;
         alarm_ff   <= alarm_in;
         pct_ff     <= pct_in;
         tick_ff    <= tick_in;
         half_ff    <= half_in;
         elapsed_ff <= elapsed_in;
         phase_ff   <= phase_in;
         div_cnt_ff <= div_cnt_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff       <= ok_in;
      mv_ff       <= mv_in;
      prod_ff     <= prod_in;
      disp_ff     <= disp_in;
      volt_ff     <= volt_in;
      red_ff      <= red_in;
      blue_ff     <= blue_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      den_ff      <= den_in;
      div_zero_ff <= div_zero_in;
      div_sat_ff  <= div_sat_in;
      frame_ff    <= frame_in;
   end

   // Input and output sides are never open in the same cycle.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("req and rsp open together");

   // The last word of a frame hands control back to idle.
   a_idle_after_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("sequencer did not return to idle after the frame");

   // An invalid reading shows a dark LED and a zero voltage.
   a_invalid_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !ok_ff) |-> (!frame_ff[FRAME_BITS-1] && (volt_ff == '0)))
      else $error("invalid reading produced a lit bit or a voltage");

   // The divider never iterates with an exhausted step count.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_DIV_STEP) |-> (div_cnt_ff != '0))
      else $error("divider stepped past its count");

   // The bit counter stays within one frame while words are shown.
   a_bit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (bit_cnt_ff <= LAST_BIT))
      else $error("bit counter ran past the frame");

endmodule

`default_nettype wire
